FILE: rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned ALIGN_W = 17;

  // Reset values of the two config registers
  localparam logic [ADDR_W-1:0] RST_BASE  = 32'h0000_0000;
  localparam logic [LEN_W-1:0]  RST_BYTES = 25'h100_0000;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } stat_t;

  // Free extent held in one cell
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } ext_t;

  // Allocation record kept in RAM
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } rec_t;

  // Broadcast command to the cell row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_WRITE,   // load data at idx
    CMD_INSERT,  // load data at idx, cells above take lower neighbor
    CMD_REMOVE,  // cells at idx and above take upper neighbor
    CMD_MERGE    // load data at idx, cells above take upper neighbor
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    ext_t data;
  } ext_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_FIND,
    S_EXT_PAD,
    S_EXT_FIT,
    S_FR_RD,
    S_FR_CMP,
    S_FR_SCAN,
    S_FR_EDIT
  } state_t;

  // Padding that puts a header below the next aligned address
  function automatic logic [ALIGN_W-1:0] pad_adj(input logic [15:0] st_lo,
                                                 input logic [3:0] alog,
                                                 input logic [6:0] hdr);
    logic [ALIGN_W-1:0] mask;
    logic [ALIGN_W-1:0] a0;
    logic [ALIGN_W-1:0] need;
    logic [ALIGN_W-1:0] adj;
    mask = (ALIGN_W'(1) << alog) - ALIGN_W'(1);
    a0   = (ALIGN_W'(0) - {1'b0, st_lo}) & mask;
    need = ALIGN_W'(hdr) - a0;
    adj  = a0;
    if (a0 < ALIGN_W'(hdr)) begin
      adj = a0 + ((need + mask) & ~mask);
    end
    return adj;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/first_fit_free_list_allocator_top.sv
`default_nettype none
// First-fit allocator over a byte pool. An item is taken when start is high
// and busy low; busy stays high until the result strobe, and out_valid marks
// the single cycle in which the result ports carry the answer (no stall is
// possible on that side). Free extents sit in a row of cells sorted by
// address; records sit in a RAM. Clear, null free, zero size and unused codes
// finish in the accepting state. An allocate first searches for the first
// free record slot, one record at a time, then, if a slot is free, pads and
// fit-tests each extent in turn until one fits or none are left; a free reads
// and compares records one at a time, walks past extents one cell per cycle up
// to the block end, stops, and then edits the cell row.
// Register writes take effect at the next clear.
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_FREE_EXTENTS = 16,
  parameter int unsigned MAX_RECORDS      = 32,
  parameter int unsigned HEADER_BYTES     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [24:0] in_req_size,
  input  wire logic [3:0]  in_align_log2,
  input  wire logic [31:0] in_free_address,
  // result channel
  output logic             out_valid,
  output logic [31:0]      out_result_address,
  output logic [2:0]       out_status,
  output logic [$clog2(MAX_RECORDS+1)-1:0] out_live_allocations,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned EIW = $clog2(MAX_FREE_EXTENTS);
  localparam int unsigned ECW = $clog2(MAX_FREE_EXTENTS+1);
  localparam int unsigned RIW = $clog2(MAX_RECORDS);
  localparam int unsigned LW  = $clog2(MAX_RECORDS+1);
  localparam logic [ECW-1:0] EXT_MAX = ECW'(MAX_FREE_EXTENTS);
  localparam logic [RIW-1:0] REC_LAST = RIW'(MAX_RECORDS-1);
  localparam logic [6:0] HDR = 7'(HEADER_BYTES);
  localparam logic [32:0] TOP_OF_MEM = 33'h1_0000_0000;

  // config registers
  logic [31:0] base_r;
  logic [24:0] bytes_r;

  // control and working registers
  state_t state_r, state_nxt;
  logic [24:0] size_r;
  logic [3:0]  alog_r;
  logic [31:0] faddr_r;
  logic [RIW-1:0] idx_r, idx_nxt;
  logic [RIW-1:0] slot_r, slot_nxt;
  logic [ECW-1:0] ext_i_r, ext_i_nxt;
  logic [ECW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0]  live_r, live_nxt;
  logic [MAX_RECORDS-1:0] vld_r, vld_nxt;
  ext_t cur_r, cur_nxt;
  logic [ALIGN_W-1:0] adj_r, adj_nxt;
  logic [31:0] bs_r, bs_nxt;
  logic [24:0] bl_r, bl_nxt;
  logic [32:0] be_r, be_nxt;
  logic [32:0] prev_end_r, prev_end_nxt;
  logic [31:0] lo_start_r, lo_start_nxt;
  logic [24:0] lo_len_r, lo_len_nxt;
  logic [24:0] hi_len_r, hi_len_nxt;
  logic mlo_r, mlo_nxt, mhi_r, mhi_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  stat_t       out_stat_r, out_stat_nxt;

  // cell row
  ext_t     cell_q [MAX_FREE_EXTENTS];
  ext_ctl_t ctl;
  logic [EIW-1:0] ctl_idx;

  // record RAM
  logic           rec_we;
  logic [RIW-1:0] rec_raddr;
  rec_t           rec_wdata, rec_rdata;

  //--------------------------------------------------------------
  // Shared decode
  //--------------------------------------------------------------
  logic accept;
  ext_t ext_cur;
  logic [25:0] total;
  logic        fit;
  logic [24:0] rem;
  logic        whole;
  logic        rec_hit;
  logic        scan_stop;
  logic [32:0] pool_end;
  ext_t        pool_ext;
  logic [ECW-1:0] ext_im1;

  assign accept    = start && (state_r == S_IDLE);
  assign ext_cur   = cell_q[ext_i_r[EIW-1:0]];
  assign total     = 26'(size_r) + 26'(adj_r);
  assign fit       = {1'b0, cur_r.len} >= total;
  assign rem       = cur_r.len - total[24:0];
  assign whole     = rem <= 25'(HEADER_BYTES);
  assign rec_hit   = vld_r[idx_r] && (rec_rdata.addr == faddr_r);
  assign scan_stop = (ext_i_r >= cnt_r) || ({1'b0, ext_cur.start} >= be_r);
  assign ext_im1   = ext_i_r - ECW'(1);

  // whole-pool extent, cut at the top of memory
  assign pool_end       = {1'b0, base_r} + 33'(bytes_r);
  assign pool_ext.start = base_r;
  assign pool_ext.len   = (pool_end > TOP_OF_MEM) ? 25'(TOP_OF_MEM - {1'b0, base_r})
                                                  : bytes_r;

  //--------------------------------------------------------------
  // Next state
  //--------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ALLOC && in_req_size != 25'd0) state_nxt = S_REC_FIND;
          else if (in_operation == OP_FREE && in_free_address != 32'd0)
            state_nxt = S_FR_RD;
        end
      end
      S_REC_FIND: begin
        if (!vld_r[idx_r]) state_nxt = S_EXT_PAD;
        else if (idx_r == REC_LAST) state_nxt = S_IDLE;
      end
      S_EXT_PAD: begin
        if (ext_i_r >= cnt_r) state_nxt = S_IDLE;
        else state_nxt = S_EXT_FIT;
      end
      S_EXT_FIT: begin
        if (fit) state_nxt = S_IDLE;
        else state_nxt = S_EXT_PAD;
      end
      S_FR_RD: state_nxt = S_FR_CMP;
      S_FR_CMP: begin
        if (rec_hit) state_nxt = S_FR_SCAN;
        else if (idx_r == REC_LAST) state_nxt = S_IDLE;
        else state_nxt = S_FR_RD;
      end
      S_FR_SCAN: begin
        if (scan_stop) state_nxt = S_FR_EDIT;
      end
      S_FR_EDIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  //--------------------------------------------------------------
  // Datapath and outputs
  //--------------------------------------------------------------
  always_comb begin
    idx_nxt      = idx_r;
    slot_nxt     = slot_r;
    ext_i_nxt    = ext_i_r;
    cnt_nxt      = cnt_r;
    live_nxt     = live_r;
    vld_nxt      = vld_r;
    cur_nxt      = cur_r;
    adj_nxt      = adj_r;
    bs_nxt       = bs_r;
    bl_nxt       = bl_r;
    be_nxt       = be_r;
    prev_end_nxt = prev_end_r;
    lo_start_nxt = lo_start_r;
    lo_len_nxt   = lo_len_r;
    hi_len_nxt   = hi_len_r;
    mlo_nxt      = mlo_r;
    mhi_nxt      = mhi_r;
    out_valid_nxt = 1'b0;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    ctl.cmd   = CMD_HOLD;
    ctl.data  = pool_ext;
    ctl_idx   = '0;
    rec_we    = 1'b0;
    rec_raddr = idx_r;
    rec_wdata.addr  = 32'(cur_r.start + 32'(adj_r));
    rec_wdata.start = cur_r.start;
    rec_wdata.len   = whole ? cur_r.len : total[24:0];

    case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        ext_i_nxt = '0;
        if (accept) begin
          out_addr_nxt = 32'd0;
          out_stat_nxt = ST_OK;
          if (in_operation == OP_ALLOC) begin
            if (in_req_size == 25'd0) begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = ST_ZERO;
            end
          end else if (in_operation == OP_FREE) begin
            if (in_free_address == 32'd0) out_valid_nxt = 1'b1;
          end else if (in_operation == OP_CLEAR) begin
            // one extent covering the pool, all records dropped
            ctl.cmd       = CMD_WRITE;
            ctl.data      = pool_ext;
            ctl_idx       = '0;
            cnt_nxt       = ECW'(1);
            vld_nxt       = '0;
            live_nxt      = '0;
            out_valid_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end

      // first free record slot
      S_REC_FIND: begin
        if (!vld_r[idx_r]) begin
          slot_nxt = idx_r;
        end else if (idx_r == REC_LAST) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = ST_FULL;
        end else begin
          idx_nxt = idx_r + RIW'(1);
        end
      end

      // fetch extent and pad its start
      S_EXT_PAD: begin
        if (ext_i_r >= cnt_r) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = ST_NOFIT;
        end else begin
          cur_nxt = ext_cur;
          adj_nxt = pad_adj(ext_cur.start[15:0], alog_r, HDR);
        end
      end

      // fit test, then take whole or split
      S_EXT_FIT: begin
        if (fit) begin
          ctl_idx = ext_i_r[EIW-1:0];
          if (whole) begin
            ctl.cmd = CMD_REMOVE;
            cnt_nxt = cnt_r - ECW'(1);
          end else begin
            ctl.cmd        = CMD_WRITE;
            ctl.data.start = 32'(cur_r.start + 32'(total));
            ctl.data.len   = rem;
          end
          rec_we          = 1'b1;
          vld_nxt[slot_r] = 1'b1;
          live_nxt        = live_r + LW'(1);
          out_valid_nxt   = 1'b1;
          out_stat_nxt    = ST_OK;
          out_addr_nxt    = rec_wdata.addr;
        end else begin
          ext_i_nxt = ext_i_r + ECW'(1);
        end
      end

      S_FR_RD: rec_raddr = idx_r;

      // record lookup, one RAM beat per entry
      S_FR_CMP: begin
        if (rec_hit) begin
          slot_nxt  = idx_r;
          bs_nxt    = rec_rdata.start;
          bl_nxt    = rec_rdata.len;
          be_nxt    = {1'b0, rec_rdata.start} + 33'(rec_rdata.len);
          ext_i_nxt = '0;
        end else if (idx_r == REC_LAST) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = ST_UNKNOWN;
        end else begin
          idx_nxt = idx_r + RIW'(1);
        end
      end

      // find first extent at or above the block end
      S_FR_SCAN: begin
        if (scan_stop) begin
          mlo_nxt    = (ext_i_r != '0) && (prev_end_r == {1'b0, bs_r});
          mhi_nxt    = (ext_i_r < cnt_r) && ({1'b0, ext_cur.start} == be_r);
          hi_len_nxt = ext_cur.len;
        end else begin
          prev_end_nxt = {1'b0, ext_cur.start} + 33'(ext_cur.len);
          lo_start_nxt = ext_cur.start;
          lo_len_nxt   = ext_cur.len;
          ext_i_nxt    = ext_i_r + ECW'(1);
        end
      end

      // merge with neighbors or insert, else report full
      S_FR_EDIT: begin
        out_valid_nxt = 1'b1;
        out_stat_nxt  = ST_OK;
        if (mlo_r && mhi_r) begin
          ctl.cmd        = CMD_MERGE;
          ctl_idx        = ext_im1[EIW-1:0];
          ctl.data.start = lo_start_r;
          ctl.data.len   = lo_len_r + bl_r + hi_len_r;
          cnt_nxt        = cnt_r - ECW'(1);
        end else if (mlo_r) begin
          ctl.cmd        = CMD_WRITE;
          ctl_idx        = ext_im1[EIW-1:0];
          ctl.data.start = lo_start_r;
          ctl.data.len   = lo_len_r + bl_r;
        end else if (mhi_r) begin
          ctl.cmd        = CMD_WRITE;
          ctl_idx        = ext_i_r[EIW-1:0];
          ctl.data.start = bs_r;
          ctl.data.len   = hi_len_r + bl_r;
        end else if (cnt_r < EXT_MAX) begin
          ctl.cmd        = CMD_INSERT;
          ctl_idx        = ext_i_r[EIW-1:0];
          ctl.data.start = bs_r;
          ctl.data.len   = bl_r;
          cnt_nxt        = cnt_r + ECW'(1);
        end else begin
          out_stat_nxt = ST_FULL;
        end
        if (mlo_r || mhi_r || cnt_r < EXT_MAX) begin
          vld_nxt[slot_r] = 1'b0;
          if (live_r != '0) live_nxt = live_r - LW'(1);
        end
      end

      default: ;
    endcase
  end

  //--------------------------------------------------------------
  // Registers
  //--------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= ECW'(1);
      live_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= RST_BASE;
      bytes_r     <= RST_BYTES;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      live_r      <= live_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2]) bytes_r <= pwdata[24:0];
        else base_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      size_r  <= in_req_size;
      alog_r  <= in_align_log2;
      faddr_r <= in_free_address;
    end
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    ext_i_r    <= ext_i_nxt;
    cur_r      <= cur_nxt;
    adj_r      <= adj_nxt;
    bs_r       <= bs_nxt;
    bl_r       <= bl_nxt;
    be_r       <= be_nxt;
    prev_end_r <= prev_end_nxt;
    lo_start_r <= lo_start_nxt;
    lo_len_r   <= lo_len_nxt;
    hi_len_r   <= hi_len_nxt;
    mlo_r      <= mlo_nxt;
    mhi_r      <= mhi_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  //--------------------------------------------------------------
  // Cell row of free extents
  //--------------------------------------------------------------
  for (genvar k = 0; k < MAX_FREE_EXTENTS; k++) begin : g_cell
    ext_t nb_lo, nb_hi, rv;
    assign nb_lo = (k == 0) ? cell_q[k] : cell_q[(k == 0) ? 0 : k-1];
    assign nb_hi = (k == MAX_FREE_EXTENTS-1) ? cell_q[k]
                 : cell_q[(k == MAX_FREE_EXTENTS-1) ? k : k+1];
    assign rv.start = RST_BASE;
    assign rv.len   = (k == 0) ? RST_BYTES : '0;
    ffa_cell #(.IW(EIW), .IDX(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .rst_val (rv),
      .ctl     (ctl),
      .idx     (ctl_idx),
      .nb_lo   (nb_lo),
      .nb_hi   (nb_hi),
      .q       (cell_q[k])
    );
  end

  //--------------------------------------------------------------
  // Record store
  //--------------------------------------------------------------
  ffa_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_RECORDS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (slot_r),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  //--------------------------------------------------------------
  // Ports
  //--------------------------------------------------------------
  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_result_address   = out_addr_r;
  assign out_status           = out_stat_r;
  assign out_live_allocations = live_r;
  assign pready               = 1'b1;
  assign prdata               = paddr[2] ? 32'(bytes_r) : base_r;

endmodule
`default_nettype wire

FILE: rtl/ffa_ram.sv
`default_nettype none
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/ffa_cell.sv
`default_nettype none
module ffa_cell
  import ffa_pkg::*;
#(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ext_t          rst_val,
  input  wire ext_ctl_t      ctl,
  input  wire logic [IW-1:0] idx,
  input  wire ext_t          nb_lo,
  input  wire ext_t          nb_hi,
  output ext_t               q
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  ext_t q_nxt;

  // Local decision from the broadcast command and own position
  always_comb begin
    q_nxt = q;
    case (ctl.cmd)
      CMD_WRITE: begin
        if (MY_IDX == idx) q_nxt = ctl.data;
      end
      CMD_INSERT: begin
        if (MY_IDX == idx) q_nxt = ctl.data;
        else if (MY_IDX > idx) q_nxt = nb_lo;
      end
      CMD_REMOVE: begin
        if (MY_IDX >= idx) q_nxt = nb_hi;
      end
      CMD_MERGE: begin
        if (MY_IDX == idx) q_nxt = ctl.data;
        else if (MY_IDX > idx) q_nxt = nb_hi;
      end
      default: q_nxt = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q <= rst_val;
    end else begin
      q <= q_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: verif/first_fit_free_list_allocator_top_test.sv
module first_fit_free_list_allocator_top_test;
  import ffa_pkg::*;

  localparam int NUM_EXT = 16;
  localparam int NUM_REC = 32;
  localparam int HDR = 16;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_POOL_BASE = 3'd0;
  localparam logic [2:0] REG_POOL_BYTES = 3'd4;

  typedef struct {
    logic [31:0] addr;
    stat_t status;
    logic [5:0] live;
  } grant_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_operation;
  logic [24:0] in_req_size;
  logic [3:0] in_align_log2;
  logic [31:0] in_free_address;
  logic out_valid;
  logic [31:0] out_result_address;
  logic [2:0] out_status;
  logic [5:0] out_live_allocations;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  first_fit_free_list_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_req_size(in_req_size),
    .in_align_log2(in_align_log2), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_result_address(out_result_address),
    .out_status(out_status), .out_live_allocations(out_live_allocations),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // allocator shadow state
  logic [31:0] shadow_base;
  logic [31:0] shadow_bytes;
  logic [63:0] ext_start [NUM_EXT];
  logic [63:0] ext_len [NUM_EXT];
  int ext_count;
  logic [31:0] rec_addr [NUM_REC];
  logic [63:0] rec_start [NUM_REC];
  logic [63:0] rec_len [NUM_REC];
  logic rec_valid [NUM_REC];
  int live_count;

  grant_t pending_grants [$];
  int mismatches;
  int stall_cycles;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void restore_pool();
    logic [63:0] len;
    len = {39'd0, shadow_bytes[24:0]};
    if ({32'd0, shadow_base} + len > 64'h1_0000_0000)
      len = 64'h1_0000_0000 - {32'd0, shadow_base};
    ext_start[0] = {32'd0, shadow_base};
    ext_len[0] = len;
    ext_count = 1;
    for (int r = 0; r < NUM_REC; r++) rec_valid[r] = 1'b0;
    live_count = 0;
  endfunction

  function automatic logic [63:0] header_pad(logic [63:0] st, int alog);
    logic [63:0] align;
    logic [63:0] adj;
    align = 64'd1 << alog;
    adj = (align - (st & (align - 1))) & (align - 1);
    if (adj < HDR) adj += align * ((HDR - adj + align - 1) / align);
    return adj;
  endfunction

  function automatic void drop_extent(int i);
    for (int k = i; k + 1 < ext_count; k++) begin
      ext_start[k] = ext_start[k + 1];
      ext_len[k] = ext_len[k + 1];
    end
    ext_count--;
  endfunction

  // first-fit allocate with header padding
  function automatic stat_t predict_alloc(logic [24:0] size, logic [3:0] alog,
                                          output logic [31:0] addr);
    int slot;
    logic [63:0] st;
    logic [63:0] adj;
    logic [63:0] total;
    addr = '0;
    slot = -1;
    if (size == 0) return ST_ZERO;
    for (int r = 0; r < NUM_REC; r++)
      if (!rec_valid[r] && slot < 0) slot = r;
    if (slot < 0) return ST_FULL;
    for (int i = 0; i < ext_count; i++) begin
      st = ext_start[i];
      adj = header_pad(st, alog);
      total = {39'd0, size} + adj;
      if (ext_len[i] >= total) begin
        if (ext_len[i] - total <= HDR) begin
          total = ext_len[i];
          drop_extent(i);
        end else begin
          ext_start[i] = st + total;
          ext_len[i] -= total;
        end
        rec_valid[slot] = 1'b1;
        rec_addr[slot] = 32'(st + adj);
        rec_start[slot] = st;
        rec_len[slot] = total;
        live_count++;
        addr = 32'(st + adj);
        return ST_OK;
      end
    end
    return ST_NOFIT;
  endfunction

  // release with coalescing on both sides
  function automatic stat_t predict_release(logic [31:0] faddr);
    int r;
    int i;
    logic [63:0] bs;
    logic [63:0] be;
    bit lo;
    bit hi;
    r = -1;
    if (faddr == 0) return ST_OK;
    for (int k = 0; k < NUM_REC; k++)
      if (r < 0 && rec_valid[k] && rec_addr[k] == faddr) r = k;
    if (r < 0) return ST_UNKNOWN;
    bs = rec_start[r];
    be = bs + rec_len[r];
    i = ext_count;
    for (int k = ext_count - 1; k >= 0; k--)
      if (ext_start[k] >= be) i = k;
    lo = i > 0 && ext_start[i - 1] + ext_len[i - 1] == bs;
    hi = i < ext_count && ext_start[i] == be;
    if (lo && hi) begin
      ext_len[i - 1] += rec_len[r] + ext_len[i];
      drop_extent(i);
    end else if (lo) begin
      ext_len[i - 1] += rec_len[r];
    end else if (hi) begin
      ext_start[i] = bs;
      ext_len[i] += rec_len[r];
    end else begin
      if (ext_count >= NUM_EXT) return ST_FULL;
      for (int k = ext_count; k > i; k--) begin
        ext_start[k] = ext_start[k - 1];
        ext_len[k] = ext_len[k - 1];
      end
      ext_start[i] = bs;
      ext_len[i] = rec_len[r];
      ext_count++;
    end
    rec_valid[r] = 1'b0;
    live_count--;
    return ST_OK;
  endfunction

  function automatic logic [31:0] pick_live_addr();
    int n;
    int want;
    n = 0;
    for (int r = 0; r < NUM_REC; r++) if (rec_valid[r]) n++;
    if (n == 0) return 32'h0000_0001;
    want = $urandom_range(n - 1);
    for (int r = 0; r < NUM_REC; r++)
      if (rec_valid[r]) begin
        if (want == 0) return rec_addr[r];
        want--;
      end
    return 32'h0000_0001;
  endfunction

  // send one command beat; start stays high for a following beat
  task automatic send_cmd(logic [1:0] op, logic [24:0] size, logic [3:0] alog,
                          logic [31:0] faddr);
    grant_t g;
    bit taken;
    if (!no_idle && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_req_size <= size;
    in_align_log2 <= alog;
    in_free_address <= faddr;
    // busy is settled at the falling edge and holds through the next rising edge
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    g.addr = '0;
    g.status = ST_OK;
    case (op)
      OP_ALLOC: g.status = predict_alloc(size, alog, g.addr);
      OP_FREE: g.status = predict_release(faddr);
      OP_CLEAR: restore_pool();
      default: ;
    endcase
    g.live = 6'(live_count);
    pending_grants.push_back(g);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write while idle; a later clear makes the pool pick it up
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_POOL_BASE) shadow_base = data;
    else shadow_bytes = data & 32'h01FF_FFFF;
  endtask

  task automatic set_pool(logic [31:0] base, logic [31:0] bytes);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_POOL_BYTES, bytes);
    send_cmd(OP_CLEAR, '0, '0, '0);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result beat", out_result_address, '0);
      end else begin
        g = pending_grants.pop_front();
        if (out_result_address !== g.addr)
          report_mismatch("result_address", out_result_address, g.addr);
        if (out_status !== g.status)
          report_mismatch("status", 32'(out_status), 32'(g.status));
        if (out_live_allocations !== g.live)
          report_mismatch("live_allocations", 32'(out_live_allocations), 32'(g.live));
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_edge_cases();
    logic [31:0] a;
    send_cmd(OP_ALLOC, 25'd0, 4'd3, '0);
    send_cmd(OP_ALLOC, 25'd1, 4'd0, '0);
    a = pick_live_addr();
    send_cmd(OP_ALLOC, 25'd100, 4'd12, '0);
    send_cmd(OP_ALLOC, 25'd7, 4'd15, '0);
    send_cmd(OP_ALLOC, 25'h1FF_FFFF, 4'd0, '0);
    send_cmd(OP_ALLOC, 25'h100_0000, 4'd0, '0);
    send_cmd(OP_FREE, '0, '0, 32'd0);
    send_cmd(OP_FREE, '0, '0, 32'hFFFF_FFFF);
    send_cmd(OP_FREE, '0, '0, a);
    send_cmd(OP_FREE, '0, '0, a);
    send_cmd(OP_UNUSED, 25'h1FF_FFFF, 4'hF, 32'hFFFF_FFFF);
    send_cmd(OP_FREE, '0, '0, pick_live_addr());
    send_cmd(OP_CLEAR, '0, '0, '0);
  endtask

  // fill every record, then fragment until the extent table overflows
  task automatic test_fragmentation();
    logic [31:0] addrs [NUM_REC];
    set_pool(32'h0000_1000, 32'd4096);
    for (int k = 0; k < NUM_REC; k++) begin
      send_cmd(OP_ALLOC, 25'd16, 4'd4, '0);
      addrs[k] = pending_grants.size() ? pending_grants[$].addr : '0;
    end
    send_cmd(OP_ALLOC, 25'd16, 4'd4, '0);
    for (int k = 0; k < NUM_REC; k += 2) send_cmd(OP_FREE, '0, '0, addrs[k]);
    for (int k = 1; k < NUM_REC; k += 2) send_cmd(OP_FREE, '0, '0, addrs[k]);
  endtask

  task automatic test_pool_limits();
    set_pool(32'hFFFF_FF00, 32'h100_0000);
    send_cmd(OP_ALLOC, 25'd64, 4'd2, '0);
    send_cmd(OP_ALLOC, 25'd300, 4'd0, '0);
    send_cmd(OP_FREE, '0, '0, pick_live_addr());
    set_pool(32'h0000_2000, 32'd0);
    send_cmd(OP_ALLOC, 25'd1, 4'd0, '0);
    set_pool(32'hFFFF_FFFF, 32'h1FF_FFFF);
    send_cmd(OP_ALLOC, 25'd1, 4'd0, '0);
  endtask

  task automatic random_items(int count);
    int roll;
    logic [24:0] size;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 40) no_idle = 1'b1;
      if (n % 150 == 90) no_idle = 1'b0;
      roll = $urandom_range(99);
      size = ($urandom_range(19) == 0) ? 25'($urandom) : 25'($urandom_range(1, 400));
      if (roll < 50)
        send_cmd(OP_ALLOC, size, ($urandom_range(9) == 0) ? 4'($urandom) :
                 4'($urandom_range(0, 6)), 32'($urandom));
      else if (roll < 88)
        send_cmd(OP_FREE, 25'($urandom), 4'($urandom), pick_live_addr());
      else if (roll < 93)
        send_cmd(OP_FREE, 25'($urandom), 4'($urandom),
                 ($urandom_range(1) != 0) ? 32'($urandom) : 32'd0);
      else if (roll < 95)
        send_cmd(OP_ALLOC, 25'd0, 4'($urandom), 32'($urandom));
      else if (roll < 97)
        send_cmd(OP_UNUSED, 25'($urandom), 4'($urandom), 32'($urandom));
      else
        send_cmd(OP_CLEAR, 25'($urandom), 4'($urandom), 32'($urandom));
      if (n == count / 2) drain();
    end
  endtask

  task automatic test_random();
    set_pool(32'h8000_0000, 32'd6000);
    random_items(220);
    set_pool(32'h0000_0000, 32'h100_0000);
    random_items(200);
    set_pool(32'h0001_0010, 32'd1500);
    random_items(180);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_ALLOC;
    in_req_size <= '0;
    in_align_log2 <= '0;
    in_free_address <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatches = 0;
    no_idle = 1'b0;
    shadow_base = RST_BASE;
    shadow_bytes = {7'd0, RST_BYTES};
    restore_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_fragmentation();
    test_pool_limits();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
